[hdl/kei_pkg.sv]
package kei_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int FRAC_BITS = 16;

  // channel index width
  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // divider quotient / dividend width, also the bound on the eased sum
  localparam int QW = FRAC_BITS + 9;
  // shared multiplier operand width (signed), wide enough for the reciprocal step
  localparam int MULW = QW + 2;
  // accumulator width (signed)
  localparam int ACCW = FRAC_BITS + 18;
  // divider remainder and divisor width
  localparam int DRW = 31;
  localparam int DCW = $clog2(QW + 1);
  // divide by 100 as a multiply by ceil(2^RSH / 100), exact for sums below 2^QW
  localparam int RSH = QW + 7;
  localparam longint RECIP100 = ((longint'(1) << RSH) + 99) / 100;

  typedef logic signed [MULW-1:0] mop_t;
  typedef logic signed [2*MULW-1:0] mprod_t;

  typedef struct packed {
    logic           start;
    logic [DRW-1:0] rem;
    logic [DRW-1:0] den;
    logic [QW-1:0]  num;
    logic [DCW-1:0] steps;
  } div_req_t;

endpackage

[hdl/keyframe_ease_interpolator.sv]
// Three-channel keyframe interpolator with easing. Items are taken one at a time;
// in_ready is high only while the sequencer is idle. Set-acceleration and set-ease
// complete in the idle step; set-segment also passes through a segment step. A query
// or a restart walks the channels one after another through one shared serial divider
// and one registered multiplier: a channel at or outside its window passes from the
// evaluate step to the next-channel step, a channel inside it with Bezier easing
// waits on the divider for the normalized time, then runs fifteen sequencer steps
// holding up to eleven multiplies, the divide by 100 among them as a reciprocal
// multiply; skew takes four fewer steps and easing off ten fewer. The result waits
// in an output register, so a finished query is held until out_ready.
module keyframe_ease_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [1:0]         channel,
  input  logic [2:0]         channel_mask,
  input  logic [29:0]        event_time,
  input  logic [29:0]        duration,
  input  logic signed [15:0] start_value,
  input  logic signed [15:0] end_value,
  input  logic [6:0]         ease_in,
  input  logic [6:0]         ease_exit,
  input  logic signed [7:0]  accel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_v,
  output logic signed [15:0] pos_h,
  output logic signed [15:0] pos_r,
  output logic               moving,
  output logic [30:0]        next_key,
  output logic               has_next_key,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import kei_pkg::*;

  localparam logic [2:0] ACT_SEG   = 3'd0;
  localparam logic [2:0] ACT_ACCEL = 3'd1;
  localparam logic [2:0] ACT_EASE  = 3'd2;
  localparam logic [2:0] ACT_QUERY = 3'd3;
  localparam logic [2:0] ACT_RST   = 3'd4;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SEG   = 5'd1;
  localparam logic [4:0] S_EVAL  = 5'd2;
  localparam logic [4:0] S_DIVT  = 5'd3;
  localparam logic [4:0] S_T1    = 5'd4;
  localparam logic [4:0] S_T2    = 5'd5;
  localparam logic [4:0] S_K1    = 5'd6;
  localparam logic [4:0] S_K2    = 5'd7;
  localparam logic [4:0] S_K3    = 5'd8;
  localparam logic [4:0] S_B1    = 5'd9;
  localparam logic [4:0] S_B2    = 5'd10;
  localparam logic [4:0] S_B3    = 5'd11;
  localparam logic [4:0] S_B4    = 5'd12;
  localparam logic [4:0] S_B5    = 5'd13;
  localparam logic [4:0] S_B6    = 5'd14;
  localparam logic [4:0] S_B7    = 5'd15;
  localparam logic [4:0] S_DIVS  = 5'd16;
  localparam logic [4:0] S_I1    = 5'd17;
  localparam logic [4:0] S_I2    = 5'd18;
  localparam logic [4:0] S_I3    = 5'd19;
  localparam logic [4:0] S_NEXT  = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;
  localparam logic [4:0] S_SCALE = 5'd22;

  localparam logic [1:0] MODE_SKEW = 2'd1;
  localparam logic [1:0] MODE_BEZ  = 2'd2;

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam int OUT_CH = 3;

  function automatic logic [6:0] cap100(input logic [6:0] v);
    return (v > 7'd100) ? 7'd100 : v;
  endfunction

  // control state
  logic [4:0]     state;
  logic [CIW-1:0] cidx;
  logic           is_query;
  logic [6:0]     ds;
  logic [1:0]     mode;

  // channel state
  logic [30:0]        seg_start [NUM_CHANNELS];
  logic [30:0]        seg_end [NUM_CHANNELS];
  logic signed [15:0] from_value [NUM_CHANNELS];
  logic signed [15:0] to_value [NUM_CHANNELS];
  logic signed [7:0]  chan_accel [NUM_CHANNELS];
  logic [6:0]         chan_ease_in [NUM_CHANNELS];
  logic [6:0]         chan_ease_out [NUM_CHANNELS];

  // query results under construction
  logic signed [15:0] res_pos [OUT_CH];
  logic               res_moving;
  logic               res_has;
  logic [30:0]        res_best;

  // datapath scratch
  logic [29:0]           qx;
  logic [29:0]           qdur;
  logic signed [15:0]    qsv;
  logic signed [15:0]    qev;
  logic [FRAC_BITS-1:0]  t;
  logic [FRAC_BITS-1:0]  p;
  logic [FRAC_BITS-1:0]  q;
  logic [FRAC_BITS-1:0]  r1;
  logic [FRAC_BITS-1:0]  r2;
  logic [FRAC_BITS-1:0]  r3;
  logic [8:0]            coef_a;
  logic [8:0]            coef_b;
  logic [FRAC_BITS:0]    s;
  logic signed [ACCW-1:0] acc;
  logic signed [15:0]    cur_pos;
  logic                  interior;

  // shared units
  mop_t          ma;
  mop_t          mb;
  mprod_t        prod;
  div_req_t      div_req;
  logic [QW-1:0] div_quo;
  logic          div_done;

  logic [30:0]            x31;
  logic [30:0]            ev_start;
  logic [30:0]            ev_end;
  logic                   at_end;
  logic                   at_start;
  logic [FRAC_BITS:0]     u;
  logic [FRAC_BITS-1:0]   prod_hi;
  logic [FRAC_BITS+1:0]   scl_quo;
  logic signed [ACCW-1:0] sum;
  logic signed [ACCW-1:0] sum_adj;
  logic signed [ACCW-1:0] pos_full;
  logic signed [9:0]      acc_sat;
  logic signed [9:0]      skew_coef;
  logic [6:0]             bez_in;
  logic [6:0]             bez_out;
  logic                   accept;

  kei_mul u_mul (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (prod)
  );

  kei_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .quo  (div_quo),
    .done (div_done)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  assign x31 = {1'b0, qx};
  assign ev_start = seg_start[cidx];
  assign ev_end = seg_end[cidx];
  assign at_end = (ev_end <= x31);
  assign at_start = (x31 <= ev_start);
  assign u = ONE - {1'b0, t};
  assign prod_hi = prod[2*FRAC_BITS-1:FRAC_BITS];
  // eased sum divided by 100
  assign scl_quo = prod[RSH+FRAC_BITS+1:RSH];
  assign sum = acc + ACCW'(prod);
  // truncate toward zero on the final scale-down
  assign sum_adj = sum[ACCW-1] ? sum + ACCW'(ONE - 1'b1) : sum;
  assign pos_full = sum_adj >>> FRAC_BITS;

  always_comb begin
    if (chan_accel[cidx] > 8'sd100) begin
      acc_sat = 10'sd100;
    end else if (chan_accel[cidx] < -8'sd100) begin
      acc_sat = -10'sd100;
    end else begin
      acc_sat = 10'(chan_accel[cidx]);
    end
    skew_coef = 10'sd100 - acc_sat;
    if (chan_ease_in[cidx] != 7'd0 || chan_ease_out[cidx] != 7'd0) begin
      bez_in = chan_ease_in[cidx];
      bez_out = chan_ease_out[cidx];
    end else begin
      bez_in = ds;
      bez_out = ds;
    end
  end

  // multiplier operand select
  always_comb begin
    case (state)
      S_T1: begin
        ma = mop_t'({1'b0, t});
        mb = mop_t'(u);
      end
      S_T2: begin
        ma = mop_t'({1'b0, t});
        mb = mop_t'({1'b0, t});
      end
      S_K1: begin
        ma = mop_t'({1'b0, p});
        mb = mop_t'(coef_a);
      end
      S_K2: begin
        ma = mop_t'({1'b0, q});
        mb = mop_t'(100);
      end
      S_B1: begin
        ma = mop_t'({1'b0, p});
        mb = mop_t'(u);
      end
      S_B2: begin
        ma = mop_t'({1'b0, p});
        mb = mop_t'({1'b0, t});
      end
      S_B3: begin
        ma = mop_t'({1'b0, q});
        mb = mop_t'({1'b0, t});
      end
      S_B4: begin
        ma = mop_t'({1'b0, r1});
        mb = mop_t'(coef_a);
      end
      S_B5: begin
        ma = mop_t'({1'b0, r2});
        mb = mop_t'(coef_b);
      end
      S_B6: begin
        ma = mop_t'({1'b0, r3});
        mb = mop_t'(100);
      end
      S_DIVS: begin
        ma = mop_t'(acc);
        mb = mop_t'(RECIP100);
      end
      S_I1: begin
        ma = mop_t'(from_value[cidx]);
        mb = mop_t'(ONE - s);
      end
      S_I2: begin
        ma = mop_t'(to_value[cidx]);
        mb = mop_t'(s);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // divider requests: normalized time
  always_comb begin
    div_req = '0;
    case (state)
      S_EVAL: begin
        div_req.start = !at_end && !at_start;
        div_req.rem = x31 - ev_start;
        div_req.den = ev_end - ev_start;
        div_req.num = '0;
        div_req.steps = DCW'(FRAC_BITS);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cidx <= '0;
      is_query <= 1'b0;
      ds <= 7'd100;
      mode <= MODE_BEZ;
      res_moving <= 1'b0;
      res_has <= 1'b0;
      res_best <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        seg_start[c] <= '0;
        seg_end[c] <= '0;
        from_value[c] <= '0;
        to_value[c] <= '0;
        chan_accel[c] <= '0;
        chan_ease_in[c] <= '0;
        chan_ease_out[c] <= '0;
      end
      for (int k = 0; k < OUT_CH; k++) begin
        res_pos[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        ds <= cfg_data;
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_SEG: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                  chan_accel[c] <= '0;
                  chan_ease_in[c] <= '0;
                  chan_ease_out[c] <= '0;
                end
                if (int'(channel) < NUM_CHANNELS) begin
                  cidx <= CIW'(channel);
                  state <= S_SEG;
                end
              end
              ACT_ACCEL: begin
                for (int c = 0; c < NUM_CHANNELS && c < 3; c++) begin
                  if (channel_mask[c]) begin
                    chan_accel[c] <= accel;
                  end
                end
              end
              ACT_EASE: begin
                for (int c = 0; c < NUM_CHANNELS && c < 3; c++) begin
                  if (channel_mask[c]) begin
                    chan_ease_in[c] <= ease_in;
                    chan_ease_out[c] <= ease_exit;
                  end
                end
              end
              ACT_QUERY, ACT_RST: begin
                cidx <= '0;
                is_query <= (action == ACT_QUERY);
                res_moving <= 1'b0;
                res_has <= 1'b0;
                res_best <= '0;
                for (int k = 0; k < OUT_CH; k++) begin
                  res_pos[k] <= '0;
                end
                state <= S_EVAL;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SEG: begin
          if (x31 >= ev_start) begin
            seg_start[cidx] <= x31;
            seg_end[cidx] <= {1'b0, qx} + {1'b0, qdur};
            from_value[cidx] <= qsv;
            to_value[cidx] <= qev;
          end
          state <= S_IDLE;
        end
        S_EVAL: begin
          if (at_end || at_start) begin
            state <= S_NEXT;
          end else begin
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_done) begin
            state <= S_T1;
          end
        end
        S_T1: begin
          mode <= (chan_accel[cidx] != 8'sd0) ? MODE_SKEW : MODE_BEZ;
          state <= (ds == 7'd0) ? S_I1 : S_T2;
        end
        S_T2: state <= (mode == MODE_SKEW) ? S_K1 : S_B1;
        S_K1: state <= S_K2;
        S_K2: state <= S_K3;
        S_K3: state <= S_DIVS;
        S_B1: state <= S_B2;
        S_B2: state <= S_B3;
        S_B3: state <= S_B4;
        S_B4: state <= S_B5;
        S_B5: state <= S_B6;
        S_B6: state <= S_B7;
        S_B7: state <= S_DIVS;
        S_DIVS: state <= S_SCALE;
        S_SCALE: state <= S_I1;
        S_I1: state <= S_I2;
        S_I2: state <= S_I3;
        S_I3: state <= S_NEXT;
        S_NEXT: begin
          if (is_query) begin
            for (int k = 0; k < OUT_CH; k++) begin
              if (k == int'(cidx)) begin
                res_pos[k] <= cur_pos;
              end
            end
            if (interior) begin
              res_moving <= 1'b1;
            end
            if (ev_end > x31 && (!res_has || ev_end < res_best)) begin
              res_best <= ev_end;
              res_has <= 1'b1;
            end
          end else begin
            from_value[cidx] <= cur_pos;
            seg_start[cidx] <= x31;
          end
          if (cidx == CIW'(NUM_CHANNELS - 1)) begin
            state <= is_query ? S_OUT : S_IDLE;
          end else begin
            cidx <= cidx + 1'b1;
            state <= S_EVAL;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= event_time;
      qdur <= duration;
      qsv <= start_value;
      qev <= end_value;
    end
    case (state)
      S_EVAL: begin
        interior <= !at_end && !at_start;
        cur_pos <= at_end ? to_value[cidx] : from_value[cidx];
      end
      S_DIVT: begin
        if (div_done) begin
          t <= div_quo[FRAC_BITS-1:0];
        end
      end
      S_T1: begin
        s <= {1'b0, t};
        if (chan_accel[cidx] != 8'sd0) begin
          coef_a <= skew_coef[8:0];
        end else begin
          coef_a <= 9'd100 - {2'b00, cap100(bez_in)};
          coef_b <= 9'd200 + {2'b00, cap100(bez_out)};
        end
      end
      S_T2: p <= prod_hi;
      S_K1: q <= prod_hi;
      S_K2: acc <= ACCW'(prod);
      S_K3: acc <= sum;
      S_B1: q <= prod_hi;
      S_B2: r1 <= prod_hi;
      S_B3: r2 <= prod_hi;
      S_B4: r3 <= prod_hi;
      S_B5: acc <= ACCW'(prod);
      S_B6: acc <= sum;
      S_B7: acc <= sum;
      S_SCALE: begin
        s <= (scl_quo > {1'b0, ONE}) ? ONE : scl_quo[FRAC_BITS:0];
      end
      S_I2: acc <= ACCW'(prod);
      S_I3: cur_pos <= pos_full[15:0];
      S_OUT: begin
        if (!out_valid || out_ready) begin
          pos_v <= res_pos[0];
          pos_h <= res_pos[1];
          pos_r <= res_pos[2];
          moving <= res_moving;
          next_key <= res_has ? res_best : 31'd0;
          has_next_key <= res_has;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVT))
    else $error("divider finished outside a wait state");

  a_ease_capped: assert property (@(posedge clk) disable iff (rst)
    (state == S_I1) |-> (s <= ONE))
    else $error("eased time above one");

  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (int'(cidx) < NUM_CHANNELS))
    else $error("channel index out of range");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output step");
`endif

endmodule

[hdl/kei_div.sv]
module kei_div (
  input  logic                  clk,
  input  logic                  rst,
  input  kei_pkg::div_req_t     req,
  output logic [kei_pkg::QW-1:0] quo,
  output logic                  done
);
  import kei_pkg::*;

  logic [DRW-1:0] rem;
  logic [DRW-1:0] den;
  logic [DCW-1:0] cnt;
  logic           busy;
  logic [DRW+1:0] trial;
  logic           ge;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {1'b0, rem, quo[QW-1]} - {2'b00, den};
  assign ge = !trial[DRW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem;
      den <= req.den;
      quo <= req.num;
    end else if (busy) begin
      rem <= ge ? trial[DRW-1:0] : {rem[DRW-2:0], quo[QW-1]};
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

[hdl/kei_mul.sv]
module kei_mul (
  input  logic            clk,
  input  kei_pkg::mop_t   a,
  input  kei_pkg::mop_t   b,
  output kei_pkg::mprod_t prod
);
  import kei_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[dv/keyframe_ease_interpolator_tb.sv]
`timescale 1ns / 1ps

module keyframe_ease_interpolator_tb;
  import kei_pkg::*;

  typedef enum logic [2:0] {
    ACT_SEGMENT = 3'd0,
    ACT_ACCEL   = 3'd1,
    ACT_EASE    = 3'd2,
    ACT_QUERY   = 3'd3,
    ACT_RESTART = 3'd4,
    ACT_RSVD5   = 3'd5,
    ACT_RSVD6   = 3'd6,
    ACT_RSVD7   = 3'd7
  } action_e;

  localparam logic [1:0] CH_V = 2'd0;
  localparam logic [1:0] CH_H = 2'd1;
  localparam logic [1:0] CH_R = 2'd2;
  localparam logic [1:0] CH_BAD = 2'd3;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam int SETTLE = 500;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic signed [15:0] pv;
    logic signed [15:0] ph;
    logic signed [15:0] pr;
    logic               mov;
    logic [30:0]        nk;
    logic               has;
  } pose_t;

  typedef struct packed {
    logic [2:0]         act;
    logic [1:0]         ch;
    logic [2:0]         msk;
    logic [29:0]        t;
    logic [29:0]        dur;
    logic signed [15:0] sv;
    logic signed [15:0] ev;
    logic [6:0]         ein;
    logic [6:0]         eout;
    logic signed [7:0]  acc;
  } cmd_t;

  typedef struct {
    cmd_t  cmd;
    bit    typed;
    pose_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] action = '0;
  logic [1:0] channel = '0;
  logic [2:0] channel_mask = '0;
  logic [29:0] event_time = '0;
  logic [29:0] duration = '0;
  logic signed [15:0] start_value = '0;
  logic signed [15:0] end_value = '0;
  logic [6:0] ease_in = '0;
  logic [6:0] ease_exit = '0;
  logic signed [7:0] accel = '0;
  logic out_valid;
  logic out_ready = 1;
  logic signed [15:0] pos_v, pos_h, pos_r;
  logic moving;
  logic [30:0] next_key;
  logic has_next_key;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  keyframe_ease_interpolator dut (
    .clk, .rst, .in_valid, .in_ready, .action, .channel, .channel_mask,
    .event_time, .duration, .start_value, .end_value, .ease_in, .ease_exit,
    .accel, .out_valid, .out_ready, .pos_v, .pos_h, .pos_r, .moving,
    .next_key, .has_next_key, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow copy of the channel state
  logic [6:0]         smoothing;
  logic [30:0]        key_start [3];
  logic [30:0]        key_stop [3];
  logic signed [15:0] val_from [3];
  logic signed [15:0] val_to [3];
  logic signed [7:0]  chan_acc [3];
  logic [6:0]         chan_ein [3];
  logic [6:0]         chan_eout [3];

  pose_t pose_q [$];
  int errors = 0;
  int quiet = 0;
  bit gaps = 1;

  function automatic longint unsigned skewed(logic signed [7:0] a, longint unsigned t);
    int acc;
    longint unsigned u, p, q;
    acc = a;
    if (acc > 100) acc = 100;
    if (acc < -100) acc = -100;
    u = ONE - t;
    p = (t * u) >> FRAC_BITS;
    q = (t * t) >> FRAC_BITS;
    return (p * longint'(100 - acc) + q * 100) / 100;
  endfunction

  function automatic longint unsigned bezier_curve(logic [6:0] ei, logic [6:0] eo,
                                                   longint unsigned t);
    longint unsigned a, b, u, p, q1, q2, q3, s;
    a = 100 - ((ei > 100) ? 100 : ei);
    b = 100 - ((eo > 100) ? 100 : eo);
    u = ONE - t;
    p = (t * u) >> FRAC_BITS;
    q1 = (p * u) >> FRAC_BITS;
    q2 = (p * t) >> FRAC_BITS;
    q3 = (((t * t) >> FRAC_BITS) * t) >> FRAC_BITS;
    s = (q1 * a + q2 * (300 - b) + q3 * 100) / 100;
    return (s > ONE) ? ONE : s;
  endfunction

  function automatic longint unsigned eased(int c, longint unsigned t);
    if (smoothing == 0) return t;
    if (chan_acc[c] != 0) return skewed(chan_acc[c], t);
    if (chan_ein[c] != 0 || chan_eout[c] != 0) return bezier_curve(chan_ein[c], chan_eout[c], t);
    return bezier_curve(smoothing, smoothing, t);
  endfunction

  // value of channel c at time x, returns 1 while strictly inside the window
  function automatic bit chan_value(int c, logic [29:0] x, output logic signed [15:0] pos);
    longint unsigned span, t, s;
    longint num;
    if ({1'b0, x} >= key_stop[c]) begin
      pos = val_to[c];
      return 0;
    end
    if ({1'b0, x} <= key_start[c]) begin
      pos = val_from[c];
      return 0;
    end
    span = 64'(key_stop[c]) - 64'(key_start[c]);
    t = ((64'(x) - 64'(key_start[c])) << FRAC_BITS) / span;
    s = eased(c, t);
    num = longint'(val_from[c]) * longint'(ONE - s) + longint'(val_to[c]) * longint'(s);
    pos = 16'(num / longint'(ONE));
    return 1;
  endfunction

  function automatic bit apply_cmd(cmd_t it, output pose_t r);
    logic signed [15:0] p [3];
    bit mov, has;
    logic [30:0] best;
    r = '0;
    case (it.act)
      ACT_SEGMENT: begin
        for (int c = 0; c < 3; c++) begin
          chan_acc[c] = 0;
          chan_ein[c] = 0;
          chan_eout[c] = 0;
        end
        if (it.ch != CH_BAD && {1'b0, it.t} >= key_start[it.ch]) begin
          key_start[it.ch] = it.t;
          key_stop[it.ch] = 31'(it.t) + 31'(it.dur);
          val_from[it.ch] = it.sv;
          val_to[it.ch] = it.ev;
        end
      end
      ACT_ACCEL, ACT_EASE: begin
        for (int c = 0; c < 3; c++) begin
          if (it.msk[c]) begin
            if (it.act == ACT_ACCEL) chan_acc[c] = it.acc;
            else begin
              chan_ein[c] = it.ein;
              chan_eout[c] = it.eout;
            end
          end
        end
      end
      ACT_RESTART: begin
        for (int c = 0; c < 3; c++) void'(chan_value(c, it.t, p[c]));
        for (int c = 0; c < 3; c++) begin
          val_from[c] = p[c];
          key_start[c] = it.t;
        end
      end
      ACT_QUERY: begin
        mov = 0;
        has = 0;
        best = '0;
        for (int c = 0; c < 3; c++) begin
          if (chan_value(c, it.t, p[c])) mov = 1;
          if (key_stop[c] > {1'b0, it.t} && (!has || key_stop[c] < best)) begin
            best = key_stop[c];
            has = 1;
          end
        end
        r = '{pv: p[0], ph: p[1], pr: p[2], mov: mov, nk: has ? best : '0, has: has};
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic issue(cmd_t it, bit typed = 0, pose_t typed_res = '0);
    pose_t r;
    if (gaps && $urandom_range(0, 99) < 14) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    action <= it.act;
    channel <= it.ch;
    channel_mask <= it.msk;
    event_time <= it.t;
    duration <= it.dur;
    start_value <= it.sv;
    end_value <= it.ev;
    ease_in <= it.ein;
    ease_exit <= it.eout;
    accel <= it.acc;
    do @(posedge clk); while (!in_ready);
    if (apply_cmd(it, r)) pose_q.push_back(typed ? typed_res : r);
  endtask

  // lets the block finish everything, results or not
  task automatic drain();
    in_valid <= 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_smoothing(logic [6:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    smoothing = v;
  endtask

  logic [29:0] now_t;

  function automatic cmd_t random_cmd();
    cmd_t it;
    int r;
    it.act = ACT_QUERY;
    it.ch = 2'($urandom_range(0, 2));
    it.msk = 3'($urandom);
    it.t = now_t + 30'($urandom_range(0, 300));
    it.dur = 30'($urandom_range(1, 400));
    it.sv = 16'($urandom);
    it.ev = 16'($urandom);
    it.ein = 7'($urandom_range(0, 100));
    it.eout = 7'($urandom_range(0, 100));
    it.acc = 8'($urandom_range(0, 200) - 100);
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it.act = ACT_SEGMENT;
      it.t = now_t + 30'($urandom_range(0, 40));
      if ($urandom_range(0, 19) == 0) it.ch = CH_BAD;
      if ($urandom_range(0, 15) == 0) it.dur = 30'($urandom_range(0, 2));
      if ($urandom_range(0, 30) == 0) it.dur = 30'($urandom);
    end else if (r < 35) begin
      it.act = ACT_ACCEL;
      if ($urandom_range(0, 5) == 0) it.acc = 8'($urandom);
    end else if (r < 45) begin
      it.act = ACT_EASE;
      if ($urandom_range(0, 5) == 0) begin
        it.ein = 7'($urandom);
        it.eout = 7'($urandom);
      end
    end else if (r < 88) begin
      it.act = ACT_QUERY;
    end else if (r < 94) begin
      it.act = ACT_RESTART;
      // restarting early reopens every channel to new segments
      if ($urandom_range(0, 2) == 0) begin
        now_t = 30'($urandom_range(0, 200));
        it.t = now_t;
      end
    end else begin
      it = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end
    now_t = now_t + 30'($urandom_range(0, 12));
    return it;
  endfunction

  row_t rows [24];

  initial begin
    logic [6:0] phase_smooth [6];
    cmd_t it;
    smoothing = 100;
    for (int c = 0; c < 3; c++) begin
      key_start[c] = 0;
      key_stop[c] = 0;
      val_from[c] = 0;
      val_to[c] = 0;
      chan_acc[c] = 0;
      chan_ein[c] = 0;
      chan_eout[c] = 0;
    end
    phase_smooth = '{7'd100, 7'd0, 7'd127, 7'd1, 7'd55, 7'd100};
    //            act          ch      msk   t            dur          sv      ev      ein eout acc
    rows[0]  = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd0,       30'd0,       16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 1, '0};
    rows[1]  = '{'{ACT_SEGMENT, CH_V,   3'd0, 30'd0, 30'h3fffffff, 16'sh7fff, 16'sh8000,
                   7'd0, 7'd0, 8'sd0}, 0, '0};
    rows[2]  = '{'{ACT_SEGMENT, CH_H,   3'd0, 30'd0, 30'd1000, 16'sh8000, 16'sh7fff,
                   7'd0, 7'd0, 8'sd0}, 0, '0};
    rows[3]  = '{'{ACT_SEGMENT, CH_R,   3'd0, 30'd10, 30'd0, 16'sd100, -16'sd100,
                   7'd0, 7'd0, 8'sd0}, 0, '0};
    rows[4]  = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd500, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[5]  = '{'{ACT_QUERY,   CH_V,   3'd0, 30'h3fffffff, 30'd0, 16'sd0, 16'sd0,
                   7'd0, 7'd0, 8'sd0}, 1, '{16'sh8000, 16'sh7fff, -16'sd100, 1'b0, 31'd0, 1'b0}};
    rows[6]  = '{'{ACT_ACCEL,   CH_V,   3'd7, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd100},
                 0, '0};
    rows[7]  = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd250, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[8]  = '{'{ACT_ACCEL,   CH_V,   3'd1, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, -8'sd100},
                 0, '0};
    rows[9]  = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd750, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[10] = '{'{ACT_ACCEL,   CH_V,   3'd2, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sh80},
                 0, '0};
    rows[11] = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd999, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[12] = '{'{ACT_EASE,    CH_V,   3'd7, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd100, 7'd0, 8'sd0},
                 0, '0};
    rows[13] = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd300, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[14] = '{'{ACT_EASE,    CH_V,   3'd5, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd127, 7'd127, 8'sd0},
                 0, '0};
    rows[15] = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd1, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[16] = '{'{ACT_RESTART, CH_V,   3'd0, 30'd600, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[17] = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd700, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[18] = '{'{ACT_SEGMENT, CH_BAD, 3'd0, 30'd900, 30'd5, 16'sd1, 16'sd2, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[19] = '{'{ACT_SEGMENT, CH_H,   3'd0, 30'd5, 30'd5, 16'sd1, 16'sd2, 7'd0, 7'd0, 8'sd0},
                 0, '0};
    rows[20] = '{'{ACT_RSVD5,   CH_V,   3'd7, 30'd1, 30'd1, 16'sd1, 16'sd1, 7'd1, 7'd1, 8'sd1},
                 0, '0};
    rows[21] = '{'{ACT_RSVD6,   CH_V,   3'd7, 30'd1, 30'd1, 16'sd1, 16'sd1, 7'd1, 7'd1, 8'sd1},
                 0, '0};
    rows[22] = '{'{ACT_RSVD7,   CH_V,   3'd7, 30'd1, 30'd1, 16'sd1, 16'sd1, 7'd1, 7'd1, 8'sd1},
                 0, '0};
    rows[23] = '{'{ACT_QUERY,   CH_V,   3'd0, 30'd0, 30'd0, 16'sd0, 16'sd0, 7'd0, 7'd0, 8'sd0},
                 0, '0};

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].res);
    drain();

    now_t = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_smoothing(phase_smooth[ph]);
      // restart everything early so new segments are accepted again
      it = '0;
      it.act = ACT_RESTART;
      now_t = 0;
      issue(it);
      gaps = (ph != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          in_valid <= 0;
          while (pose_q.size() != 0) @(posedge clk);
        end
        issue(random_cmd());
      end
      drain();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    pose_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{pos_v, pos_h, pos_r, moving, next_key, has_next_key};
        if (pose_q.size() == 0) begin
          if (errors < 10) $display("unexpected query result %p", got);
          errors++;
        end else begin
          want = pose_q.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("query result wrong: expected %p got %p", want, got);
            errors++;
          end
        end
      end
      out_ready <= gaps ? ($urandom_range(0, 99) >= 14) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

[filelist.f]
hdl/kei_pkg.sv
hdl/kei_div.sv
hdl/kei_mul.sv
hdl/keyframe_ease_interpolator.sv
dv/keyframe_ease_interpolator_tb.sv
